// ----- sv/mbd_pkg.sv -----
`timescale 1ns / 1ps
// Package for the multichannel boxcar decimator: shared types and constants.
// Used by the channel interfaces, the divider and the top level. No dependencies.
package mbd_pkg;

  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 9;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES = WORD_W / DIV_STEPS_PER_STAGE;
  localparam int MAX_FRAMES = 256;
  localparam int TAG_W    = 8;

  // Register map, in units of 32-bit words
  localparam logic [1:0] REG_ELEMENT_COUNT = 2'd0;
  localparam logic [1:0] REG_WIDE_WORDS    = 2'd1;
  localparam logic [1:0] REG_FRAMES_TO_AVG = 2'd2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [COUNT_W-1:0]       count_t;

  // Per-beat information that rides alongside the divider
  typedef struct packed {
    logic  produce;    // beat yields a result
    logic  divide;     // result comes from the quotient
    logic  neg;        // sum was negative
    logic  last_word;  // last word of the frame
    logic  wide;       // 32-bit sample mode
    word_t word;       // sign-extended input word
  } side_t;

endpackage

// ----- sv/mbd_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream interfaces for the sample input and the result output.
// Depends on mbd_pkg.
interface mbd_sample_if
  import mbd_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t sample_word;
  modport source (output valid, output sample_word, input ready);
  modport sink (input valid, input sample_word, output ready);
endinterface

interface mbd_result_if
  import mbd_pkg::*;
  ();
  logic  valid;
  logic  ready;
  word_t out_word;
  logic  frame_end;
  modport source (output valid, output out_word, output frame_end, input ready);
  modport sink (input valid, input out_word, input frame_end, output ready);
endinterface

// ----- sv/mbd_divider.sv -----
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider: 32-bit dividend by a 9-bit divisor,
// four quotient bits per stage. Depends on mbd_pkg.
module mbd_divider
  import mbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [WORD_W-1:0]  dividend,
  input  count_t             divisor,
  output logic               out_valid,
  output side_t              out_side,
  output logic [WORD_W-1:0]  quotient
);

  logic              v   [DIV_STAGES];
  side_t             sd  [DIV_STAGES];
  logic [COUNT_W-2:0] rem [DIV_STAGES];
  logic [WORD_W-1:0] aq  [DIV_STAGES];

  genvar g;
  generate
    for (g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic               v_src;
      side_t              sd_src;
      logic [COUNT_W-2:0] r_src;
      logic [WORD_W-1:0]  a_src;
      logic [COUNT_W-2:0] r_next;
      logic [WORD_W-1:0]  aq_next;

      if (g == 0) begin : g_first
        assign v_src  = in_valid;
        assign sd_src = in_side;
        assign r_src  = '0;
        assign a_src  = dividend;
      end else begin : g_rest
        assign v_src  = v[g-1];
        assign sd_src = sd[g-1];
        assign r_src  = rem[g-1];
        assign a_src  = aq[g-1];
      end

      // Shift in one dividend bit per step, subtract when it fits
      always_comb begin
        logic [COUNT_W-1:0] trial;
        r_next  = r_src;
        aq_next = a_src;
        for (int s = 0; s < DIV_STEPS_PER_STAGE; s++) begin
          trial   = {r_next, aq_next[WORD_W-1]};
          aq_next = {aq_next[WORD_W-2:0], 1'b0};
          if (trial >= divisor) begin
            trial      = trial - divisor;
            aq_next[0] = 1'b1;
          end
          r_next = trial[COUNT_W-2:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          v[g] <= 1'b0;
        end else if (en) begin
          v[g] <= v_src;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sd[g]  <= sd_src;
          rem[g] <= r_next;
          aq[g]  <= aq_next;
        end
      end
    end
  endgenerate

  assign out_valid = v[DIV_STAGES-1];
  assign out_side  = sd[DIV_STAGES-1];
  assign quotient  = aq[DIV_STAGES-1];

endmodule

// ----- sv/multichannel_boxcar_decimator.sv -----
`timescale 1ns / 1ps
// Top level of the multichannel boxcar decimator: frame tracking, channel
// sum memory, divider pipeline and output register. Depends on mbd_pkg,
// mbd_if and mbd_divider.
//
//   channel   direction  payload                 handshake
//   samples   in         sample_word             valid/ready
//   results   out        out_word, frame_end     valid/ready
//   config    in         APB write/read          psel/penable, pready high
//
// One word is taken per cycle when the pipeline is not stalled. There are ten
// register stages: the sum memory read, eight divider stages of four bits
// each (the accumulate and magnitude feed the first of them) and the output
// register. The whole pipeline advances together whenever the output register
// is empty or being taken, so a stall holds every stage in place.
// Reset and any register write restart the frame and the group of frames.
module multichannel_boxcar_decimator
  import mbd_pkg::*;
#(
  parameter int MAX_CHANNELS  = 256,
  parameter int SCRATCH_BYTES = 16
)(
  input  logic               clk,
  input  logic               rst,
  mbd_sample_if.sink         samples,
  mbd_result_if.source       results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int PW = $clog2(MAX_CHANNELS + SCRATCH_BYTES / 2 + 1);
  localparam int FW = $clog2(MAX_FRAMES);
  localparam logic [PW-1:0] MAX_CH = PW'(MAX_CHANNELS);
  localparam logic [PW-1:0] SCR_WIDE   = PW'(SCRATCH_BYTES / 4);
  localparam logic [PW-1:0] SCR_NARROW = PW'(SCRATCH_BYTES / 2);

  // Configuration registers
  count_t element_count;
  logic   wide_words;
  count_t frames_to_average;
  logic   cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count     <= count_t'(1);
      wide_words        <= 1'b0;
      frames_to_average <= count_t'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ELEMENT_COUNT: element_count     <= pwdata[COUNT_W-1:0];
        REG_WIDE_WORDS:    wide_words        <= pwdata[0];
        REG_FRAMES_TO_AVG: frames_to_average <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ELEMENT_COUNT: prdata = 32'(element_count);
      REG_WIDE_WORDS:    prdata = 32'(wide_words);
      REG_FRAMES_TO_AVG: prdata = 32'(frames_to_average);
      default:           prdata = '0;
    endcase
  end

  logic cfg_hit;
  assign cfg_hit = cfg_wr &&
                   (paddr[3:2] inside {REG_ELEMENT_COUNT, REG_WIDE_WORDS, REG_FRAMES_TO_AVG});

  // Clamped counts
  logic [PW-1:0] nch;
  count_t        nacc;
  logic [PW-1:0] frame_len;
  logic [PW:0]   ec_ext;

  always_comb begin
    ec_ext = (PW+1)'(element_count);
    if (element_count == '0) begin
      nch = PW'(1);
    end else if (ec_ext > (PW+1)'(MAX_CHANNELS)) begin
      nch = MAX_CH;
    end else begin
      nch = ec_ext[PW-1:0];
    end
    if (frames_to_average == '0) begin
      nacc = count_t'(1);
    end else if (frames_to_average > count_t'(MAX_FRAMES)) begin
      nacc = count_t'(MAX_FRAMES);
    end else begin
      nacc = frames_to_average;
    end
    frame_len = nch + (wide_words ? SCR_WIDE : SCR_NARROW);
  end

  // Pipeline advance
  logic en;
  logic acc_in;
  assign en            = !results.valid || results.ready;
  assign samples.ready = en;
  assign acc_in        = en && samples.valid;

  // Frame position tracking
  logic [PW-1:0] pos;
  logic [FW-1:0] frames_seen;
  logic          last_word;
  logic          last_frame;
  logic          pass;
  logic          is_chan;

  assign last_word  = (PW+1)'(pos) + (PW+1)'(1) >= (PW+1)'(frame_len);
  assign last_frame = (COUNT_W)'(frames_seen) + count_t'(1) >= nacc;
  assign pass       = (nacc == count_t'(1));
  assign is_chan    = pos < nch;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      pos         <= '0;
      frames_seen <= '0;
    end else if (acc_in) begin
      if (last_word) begin
        pos <= '0;
        if (!pass) begin
          frames_seen <= last_frame ? '0 : frames_seen + FW'(1);
        end
      end else begin
        pos <= pos + PW'(1);
      end
    end
  end

  // Sign-extend and form the summed term
  word_t word_in;
  word_t term_in;
  assign word_in = wide_words ? samples.sample_word
                              : word_t'($signed(samples.sample_word[15:0]));
  assign term_in = wide_words ? (word_in >>> TAG_W) : word_in;

  // Stage 1 registers
  logic          v1;
  logic          wr1;
  logic          first1;
  logic [AW-1:0] addr1;
  word_t         term1;
  side_t         side1;
  logic          fwd1;
  word_t         fwd_data1;
  word_t         rd1;
  word_t         sum1;

  logic [AW-1:0] addr_in;
  assign addr_in = AW'(pos);

  word_t sum_mem [MAX_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr1    <= samples.valid && !pass && is_chan;
      first1 <= (frames_seen == '0);
      addr1  <= addr_in;
      term1  <= term_in;
      side1.produce   <= pass || last_frame;
      side1.divide    <= !pass && is_chan;
      side1.neg       <= 1'b0;
      side1.last_word <= last_word;
      side1.wide      <= wide_words;
      side1.word      <= word_in;
      // Forward the sum being written this edge to a read of the same entry
      fwd1      <= v1 && wr1 && (addr1 == addr_in);
      fwd_data1 <= sum1;
    end
  end

  // Sum memory: read on accept, write back one stage later
  always_ff @(posedge clk) begin
    if (en) begin
      rd1 <= sum_mem[addr_in];
      if (v1 && wr1) begin
        sum_mem[addr1] <= sum1;
      end
    end
  end

  // Accumulate; the first frame of a group starts from zero
  always_comb begin
    sum1 = term1 + (first1 ? word_t'(0) : (fwd1 ? fwd_data1 : rd1));
  end

  side_t             side1_div;
  logic [WORD_W-1:0] mag1;

  always_comb begin
    side1_div     = side1;
    side1_div.neg = sum1[WORD_W-1];
    mag1          = sum1[WORD_W-1] ? WORD_W'(-sum1) : WORD_W'(sum1);
  end

  logic              vd;
  side_t             sd;
  logic [WORD_W-1:0] qd;

  mbd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .in_side   (side1_div),
    .dividend  (mag1),
    .divisor   (nacc),
    .out_valid (vd),
    .out_side  (sd),
    .quotient  (qd)
  );

  // Restore sign and format the output word
  word_t q_signed;
  word_t result_next;

  always_comb begin
    q_signed = sd.neg ? word_t'(-qd) : word_t'(qd);
    if (!sd.divide) begin
      result_next = sd.word;
    end else if (sd.wide) begin
      result_next = {q_signed[WORD_W-TAG_W-1:0], sd.word[TAG_W-1:0]};
    end else begin
      result_next = q_signed;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en) begin
      results.valid <= vd && sd.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      results.out_word  <= result_next;
      results.frame_end <= sd.last_word;
    end
  end

endmodule
